### hw/rtl/hdps_pkg.sv
// Package for the half-duplex PTT burst scheduler.
// Holds the configuration struct, register indexes, reset values and fixed widths.
// No dependencies; used by hdps_regs, hdps_fifo_mem and the top level.
package hdps_pkg;

  // Fixed field widths.
  localparam int LenW   = 10;  // frame length in bytes
  localparam int BytesW = 17;  // bytes released in one step (at most 127 frames plus preamble)
  localparam int CntW   = 7;   // frame counts on the result side
  localparam int TimeW  = 32;  // millisecond time base

  // floor(x / 18) for x < 2^20 is (x * RECIP18) >> DIV_SHIFT.
  localparam int XW        = 20;
  localparam int RecipW    = 21;
  localparam int ProdW     = XW + RecipW;
  localparam int DIV_SHIFT = 25;
  localparam logic [RecipW-1:0] RECIP18 = 21'd1864136;
  localparam int QuotW     = ProdW - DIV_SHIFT;

  // Register indexes (byte address is 4 times the index).
  localparam logic [2:0] REG_BURST_CAP    = 3'd0;
  localparam logic [2:0] REG_FLUSH_TMO    = 3'd1;
  localparam logic [2:0] REG_KEY_UP_DELAY = 3'd2;
  localparam logic [2:0] REG_TURNAROUND   = 3'd3;
  localparam logic [2:0] REG_DRAIN        = 3'd4;
  localparam logic [2:0] REG_PREAMBLE     = 3'd5;

  // Reset values.
  localparam logic [6:0]  RST_BURST_CAP    = 7'd8;
  localparam logic [15:0] RST_FLUSH_TMO    = 16'd100;
  localparam logic [9:0]  RST_KEY_UP_DELAY = 10'd80;
  localparam logic [11:0] RST_TURNAROUND   = 12'd300;
  localparam logic [9:0]  RST_DRAIN        = 10'd100;
  localparam logic [7:0]  RST_PREAMBLE     = 8'd16;

  typedef struct packed {
    logic [6:0]  burst_cap;
    logic [15:0] flush_age_ms;
    logic [9:0]  key_up_delay_ms;
    logic [11:0] turnaround_ms;
    logic [9:0]  drain_ms;
    logic [7:0]  preamble_bytes;
  } cfg_t;

endpackage

### hw/rtl/half_duplex_ptt_burst_scheduler_top.sv
// Half-duplex PTT burst scheduler, top level.
// Depends on hdps_pkg, hdps_regs and hdps_fifo_mem.
//
// Usage: each transfer on the input channel (in_valid/in_ready) is either a
// one millisecond tick (operation = 0) or the enqueue of one frame length
// (operation = 1, frame_bytes). Every input transfer yields exactly one result
// transfer (out_valid/out_ready) with PTT state, key-up, frames and bytes
// released, cooldown, PTT drop, a refused enqueue and the queue level.
// Each step passes S_DROP and S_CHECK; when no release is due it goes on to
// S_OUT, otherwise through the release loop (S_REL), S_MUL, S_DIV, S_ACC,
// S_COOL when a cooldown starts, and S_OUT; at most the burst limit of frames
// is released. The release loop reads one queue entry per cycle from the
// synchronous memory; the deadline update uses a reciprocal multiply.
// in_ready rises together with out_valid. A waiting result does not stop
// the next input transfer; if the receiver stalls, that step runs to
// completion and then waits until the output register frees up, with
// in_ready low. Reset (rst, synchronous) empties the queue, zeroes time and
// deadlines, releases PTT and loads register defaults; the memory is not
// cleared. Configuration must be written only while the block is idle; the
// block itself does not enforce this. pready is always high.
module half_duplex_ptt_burst_scheduler_top #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  // Input channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [9:0]  frame_bytes,
  // Result channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic        ptt_on,
  output logic        key_up,
  output logic [6:0]  frames_released,
  output logic [16:0] bytes_released,
  output logic        cooldown_started,
  output logic        ptt_dropped,
  output logic        enqueue_dropped,
  output logic [6:0]  queue_level,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int LW = (CW > 7) ? CW : 7;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DROP,
    S_CHECK,
    S_REL,
    S_MUL,
    S_DIV,
    S_ACC,
    S_COOL,
    S_OUT
  } state_t;

  state_t state;

  hdps_pkg::cfg_t cfg;

  // Step registers.
  logic                            op;
  logic [hdps_pkg::LenW-1:0]       fbytes;
  logic                            key_up_f;
  logic                            cool_f;
  logic                            drop_f;
  logic                            refused_f;
  logic [hdps_pkg::CntW-1:0]       released;
  logic [hdps_pkg::BytesW-1:0]     bytes;
  logic                            rd_pend;
  logic [hdps_pkg::XW-1:0]         x5;
  logic [hdps_pkg::ProdW-1:0]      prod;

  // Scheduler state.
  logic [hdps_pkg::TimeW-1:0]      now_ms;
  logic [hdps_pkg::TimeW-1:0]      drop_deadline;
  logic [hdps_pkg::TimeW-1:0]      resume_time;
  logic [hdps_pkg::TimeW-1:0]      oldest_time;
  logic                            transmitting;
  logic [hdps_pkg::CntW-1:0]       fib;
  logic [CW-1:0]                   count;
  logic [AW-1:0]                   head;
  logic [AW-1:0]                   tail;

  // Queue memory interface.
  logic                            mem_we;
  logic                            mem_re;
  logic [hdps_pkg::LenW-1:0]       mem_rdata;

  // Decision logic.
  logic [6:0]                      limit;
  logic                            can_issue;
  logic                            full;
  logic [AW-1:0]                   head_inc;
  logic [AW-1:0]                   tail_inc;
  logic [hdps_pkg::TimeW-1:0]      dl_diff;
  logic [hdps_pkg::TimeW-1:0]      rs_diff;
  logic [hdps_pkg::TimeW-1:0]      age;
  logic                            threshold;
  logic                            timeout;
  logic                            send_now;
  logic                            cool_cond;
  logic [hdps_pkg::QuotW-1:0]      quot;

  assign pready = 1'b1;

  hdps_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  hdps_fifo_mem #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (tail),
    .wdata (fbytes),
    .re    (mem_re),
    .raddr (head),
    .rdata (mem_rdata)
  );

  // A burst limit of zero behaves as one.
  assign limit     = (cfg.burst_cap == 7'd0) ? 7'd1 : cfg.burst_cap;
  assign full      = (count == CW'(QUEUE_DEPTH));
  assign can_issue = (count != '0) && (fib < limit);
  assign head_inc  = (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_inc  = (tail == AW'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;

  // Times wrap; a time is reached when the difference has its top bit clear.
  assign dl_diff   = now_ms - drop_deadline;
  assign rs_diff   = now_ms - resume_time;
  assign age       = now_ms - oldest_time;
  assign threshold = LW'(count) >= LW'(limit);
  assign timeout   = age >= {16'b0, cfg.flush_age_ms};
  assign send_now  = (count != '0) && !rs_diff[hdps_pkg::TimeW-1]
                     && (threshold || timeout || transmitting);
  assign cool_cond = fib >= limit;
  assign quot      = prod[hdps_pkg::ProdW-1:hdps_pkg::DIV_SHIFT];

  assign mem_we    = (state == S_DROP) && op && !full;
  assign mem_re    = (state == S_REL) && can_issue;
  assign in_ready  = (state == S_IDLE) && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      now_ms        <= '0;
      drop_deadline <= '0;
      resume_time   <= '0;
      oldest_time   <= '0;
      transmitting  <= 1'b0;
      fib           <= '0;
      count         <= '0;
      head          <= '0;
      tail          <= '0;
      rd_pend       <= 1'b0;
    end else begin
      // The result output register empties on its transfer unless a new result
      // is loaded in the same cycle.
      if (out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op        <= operation;
            fbytes    <= frame_bytes;
            key_up_f  <= 1'b0;
            cool_f    <= 1'b0;
            drop_f    <= 1'b0;
            refused_f <= 1'b0;
            released  <= '0;
            bytes     <= '0;
            if (!operation) begin
              now_ms <= now_ms + 1'b1;
            end
            state <= S_DROP;
          end
        end
        S_DROP: begin
          // PTT release comes first, then the enqueue.
          if (transmitting && !dl_diff[hdps_pkg::TimeW-1]) begin
            transmitting <= 1'b0;
            fib          <= '0;
            drop_f       <= 1'b1;
          end
          if (op) begin
            if (full) begin
              refused_f <= 1'b1;
            end else begin
              tail  <= tail_inc;
              count <= count + 1'b1;
              if (count == '0) begin
                oldest_time <= now_ms;
              end
            end
          end
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (send_now) begin
            if (!transmitting) begin
              transmitting  <= 1'b1;
              key_up_f      <= 1'b1;
              drop_deadline <= now_ms + {22'b0, cfg.key_up_delay_ms};
              bytes         <= {9'b0, cfg.preamble_bytes};
            end
            state <= S_REL;
          end else begin
            state <= S_OUT;
          end
        end
        S_REL: begin
          // One queue read per cycle; its data is added in the next cycle.
          if (rd_pend) begin
            bytes <= bytes + hdps_pkg::BytesW'(mem_rdata);
          end
          if (can_issue) begin
            head     <= head_inc;
            count    <= count - 1'b1;
            fib      <= fib + 1'b1;
            released <= released + 1'b1;
          end
          rd_pend <= can_issue;
          if (!can_issue && !rd_pend) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          x5    <= {1'b0, bytes, 2'b00} + {3'b000, bytes};
          state <= S_DIV;
        end
        S_DIV: begin
          prod  <= {{hdps_pkg::RecipW{1'b0}}, x5}
                   * {{hdps_pkg::XW{1'b0}}, hdps_pkg::RECIP18};
          state <= S_ACC;
        end
        S_ACC: begin
          drop_deadline <= drop_deadline + hdps_pkg::TimeW'(quot)
                           + (cool_cond ? {22'b0, cfg.drain_ms} : 32'd0);
          if (cool_cond) begin
            cool_f <= 1'b1;
            state  <= S_COOL;
          end else begin
            state  <= S_OUT;
          end
        end
        S_COOL: begin
          resume_time <= drop_deadline + {20'b0, cfg.turnaround_ms};
          state       <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid        <= 1'b1;
            ptt_on           <= transmitting;
            key_up           <= key_up_f;
            frames_released  <= released;
            bytes_released   <= bytes;
            cooldown_started <= cool_f;
            ptt_dropped      <= drop_f;
            enqueue_dropped  <= refused_f;
            queue_level      <= 7'(count);
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The queue never holds more frames than it has entries.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    LW'(count) <= LW'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  // A burst only accumulates frames while PTT is keyed.
  a_burst_idle: assert property (@(posedge clk) disable iff (rst)
    !transmitting |-> (fib == '0))
    else $error("burst frame count nonzero with PTT released");

  // Read data is only collected inside the release loop.
  a_read_in_release: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (state == S_REL))
    else $error("queue read outstanding outside the release loop");

endmodule

### hw/rtl/hdps_fifo_mem.sv
// Frame length store for the scheduler queue: one write port, one read port.
// Read data is registered and appears in the cycle after the read request. Uses hdps_pkg.
module hdps_fifo_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [hdps_pkg::LenW-1:0]  wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [hdps_pkg::LenW-1:0]  rdata
);

  logic [hdps_pkg::LenW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/hdps_regs.sv
// APB-style configuration registers for the scheduler.
// Decodes word addresses, holds reset values and returns read data. Uses hdps_pkg.
module hdps_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output hdps_pkg::cfg_t     cfg
);

  logic wr_en;

  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.burst_cap        <= hdps_pkg::RST_BURST_CAP;
      cfg.flush_age_ms     <= hdps_pkg::RST_FLUSH_TMO;
      cfg.key_up_delay_ms  <= hdps_pkg::RST_KEY_UP_DELAY;
      cfg.turnaround_ms    <= hdps_pkg::RST_TURNAROUND;
      cfg.drain_ms         <= hdps_pkg::RST_DRAIN;
      cfg.preamble_bytes   <= hdps_pkg::RST_PREAMBLE;
    end else if (wr_en) begin
      case (paddr[4:2])
        hdps_pkg::REG_BURST_CAP:    cfg.burst_cap        <= pwdata[6:0];
        hdps_pkg::REG_FLUSH_TMO:    cfg.flush_age_ms     <= pwdata[15:0];
        hdps_pkg::REG_KEY_UP_DELAY: cfg.key_up_delay_ms  <= pwdata[9:0];
        hdps_pkg::REG_TURNAROUND:   cfg.turnaround_ms    <= pwdata[11:0];
        hdps_pkg::REG_DRAIN:        cfg.drain_ms         <= pwdata[9:0];
        hdps_pkg::REG_PREAMBLE:     cfg.preamble_bytes   <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      hdps_pkg::REG_BURST_CAP:    prdata = {25'b0, cfg.burst_cap};
      hdps_pkg::REG_FLUSH_TMO:    prdata = {16'b0, cfg.flush_age_ms};
      hdps_pkg::REG_KEY_UP_DELAY: prdata = {22'b0, cfg.key_up_delay_ms};
      hdps_pkg::REG_TURNAROUND:   prdata = {20'b0, cfg.turnaround_ms};
      hdps_pkg::REG_DRAIN:        prdata = {22'b0, cfg.drain_ms};
      hdps_pkg::REG_PREAMBLE:     prdata = {24'b0, cfg.preamble_bytes};
      default:                    prdata = 32'b0;
    endcase
  end

endmodule
